/* design/poly_voice_allocator_envelope_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the voice allocator
// Immediate-style wrappers around concurrent assertions, clocked on clk and
// disabled while rst_n is low. They compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_ENVELOPE_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_ENVELOPE_MACROS_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset
`define PVA_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pva assertion failed");
// Consequence holds in the cycle after the trigger
`define PVA_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("pva assertion failed");
`else
`define PVA_ASSERT(label, cond)
`define PVA_ASSERT_NEXT(label, trig, cons)
`endif

`endif

/* design/pva_pkg.sv */
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, codes and types of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    // Voice storage
    localparam int NUM_VOICES = 8;
    localparam int SLOT_W     = $clog2(NUM_VOICES);
    localparam int CNT_W      = $clog2(NUM_VOICES + 1);

    // Waveform numbers
    localparam int            WAVE_W   = 7;
    localparam logic [6:0]    WAVE_MAX = 7'd99;

    // Q1.15 levels
    localparam int            LEVEL_W   = 16;
    localparam logic [15:0]   LEVEL_ONE = 16'h8000;

    // MIDI fields
    localparam int CHAN_W = 5;
    localparam int NOTE_W = 7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Actions
    localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [1:0] ACT_ALL_OFF  = 2'd2;
    localparam logic [1:0] ACT_TICK     = 2'd3;

    // Outcomes
    localparam logic [2:0] OUT_NONE      = 3'd0;
    localparam logic [2:0] OUT_NEW       = 3'd1;
    localparam logic [2:0] OUT_RETRIG    = 3'd2;
    localparam logic [2:0] OUT_STOLEN    = 3'd3;
    localparam logic [2:0] OUT_RELEASED  = 3'd4;
    localparam logic [2:0] OUT_NOT_FOUND = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_LIMIT   = 2'd0;
    localparam logic [1:0] REG_WAVE    = 2'd1;
    localparam logic [1:0] REG_ATTACK  = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0]        act;
        logic              needs_scan;
        logic [CHAN_W-1:0] channel;
        logic [NOTE_W-1:0] note;
    } cmd_t;

    // Configuration, already clamped to legal ranges
    typedef struct packed {
        logic [CNT_W-1:0]   limit;
        logic [WAVE_W-1:0]  wave;
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] release_step;
    } cfg_t;

endpackage

/* design/poly_voice_allocator_envelope.sv */
// ----------------------------------------------------------------------------
// poly_voice_allocator_envelope
// Eight-slot polyphonic voice allocator with linear attack/release levels.
//
// Input channel (in_valid/in_stall): action, midi_channel, note_number.
// A transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall): one result per input item, in order.
// Config port: cfg_we writes cfg_wdata to register cfg_index (0 limit,
// 1 wave, 2 attack step, 3 release step); values are clamped on write.
// Items go into a two-entry queue; the back end scans the voice slots one
// per cycle. Note events and ticks pass through dispatch, a scan of all
// eight slots and commit; all-off goes from dispatch straight to commit.
// The back end takes one item at a time and pops the next only after the
// last is committed to the output register.
// Reset frees every voice and loads the register defaults. A stalled
// output holds its result; the queue keeps taking input until it is full,
// then in_stall rises.
// ----------------------------------------------------------------------------
module poly_voice_allocator_envelope (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [pva_pkg::CHAN_W-1:0]    midi_channel,
    input  logic [pva_pkg::NOTE_W-1:0]    note_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pva_pkg::SLOT_W-1:0]    slot,
    output logic [2:0]                    outcome,
    output logic [pva_pkg::CNT_W-1:0]     active_count,
    output logic [pva_pkg::NUM_VOICES-1:0] active_mask,
    output logic [pva_pkg::WAVE_W-1:0]    slot_wave
);

    pva_pkg::cfg_t   cfg_reg;
    pva_pkg::cmd_t   cmd;
    logic            cmd_valid;
    logic            cmd_pop;
    logic [3:0]      wr_limit;
    logic [6:0]      wr_wave;
    logic [15:0]     wr_step;

    // Clamp register values on write
    always_comb
    begin
        wr_limit = cfg_wdata[3:0];
        if (wr_limit == 4'd0)
        begin
            wr_limit = 4'd1;
        end
        else if (wr_limit > 4'(pva_pkg::NUM_VOICES))
        begin
            wr_limit = 4'(pva_pkg::NUM_VOICES);
        end
        wr_wave = cfg_wdata[6:0];
        if (wr_wave > pva_pkg::WAVE_MAX)
        begin
            wr_wave = pva_pkg::WAVE_MAX;
        end
        wr_step = cfg_wdata;
        if (wr_step == 16'd0)
        begin
            wr_step = 16'd1;
        end
        else if (wr_step > pva_pkg::LEVEL_ONE)
        begin
            wr_step = pva_pkg::LEVEL_ONE;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit        <= pva_pkg::CNT_W'(pva_pkg::NUM_VOICES);
            cfg_reg.wave         <= '0;
            cfg_reg.attack_step  <= 16'd171;
            cfg_reg.release_step <= 16'd6;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pva_pkg::REG_LIMIT:   cfg_reg.limit        <= wr_limit;
                pva_pkg::REG_WAVE:    cfg_reg.wave         <= wr_wave;
                pva_pkg::REG_ATTACK:  cfg_reg.attack_step  <= wr_step;
                pva_pkg::REG_RELEASE: cfg_reg.release_step <= wr_step;
                default:              cfg_reg              <= cfg_reg;
            endcase
        end
    end

    pva_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .midi_channel (midi_channel),
        .note_number  (note_number),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    pva_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot         (slot),
        .outcome      (outcome),
        .active_count (active_count),
        .active_mask  (active_mask),
        .slot_wave    (slot_wave)
    );

endmodule

/* design/pva_front.sv */
// ----------------------------------------------------------------------------
// pva_front
// Accepts input items, classifies them and holds them in a short queue
// until the back end takes them.
// ----------------------------------------------------------------------------
module pva_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [pva_pkg::CHAN_W-1:0]   midi_channel,
    input  logic [pva_pkg::NOTE_W-1:0]   note_number,
    output logic                         cmd_valid,
    output pva_pkg::cmd_t                cmd,
    input  logic                         cmd_pop
);

    pva_pkg::cmd_t                  queue_reg [pva_pkg::QUEUE_DEPTH];
    logic [pva_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [pva_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [pva_pkg::Q_CNT_W-1:0]    count_reg;
    logic [pva_pkg::Q_CNT_W-1:0]    count_next;
    pva_pkg::cmd_t                  in_cmd;
    logic                           push;
    logic                           pop;

    // Classify the incoming item
    always_comb
    begin
        in_cmd.act        = action;
        in_cmd.needs_scan = (action != pva_pkg::ACT_ALL_OFF);
        in_cmd.channel    = midi_channel;
        in_cmd.note       = note_number;
    end

    // Handshake and queue status
    assign in_stall  = (count_reg == pva_pkg::Q_CNT_W'(pva_pkg::QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* design/pva_back.sv */
// ----------------------------------------------------------------------------
// pva_back
// Carries out one command at a time: scans the voice slots one per cycle
// (all-off skips the scan), updates levels on ticks, picks the slot for
// note events, then commits the result into the output register.
// ----------------------------------------------------------------------------
`include "poly_voice_allocator_envelope_macros.svh"

module pva_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pva_pkg::cfg_t                 cfg,
    input  logic                          cmd_valid,
    input  pva_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pva_pkg::SLOT_W-1:0]    slot,
    output logic [2:0]                    outcome,
    output logic [pva_pkg::CNT_W-1:0]     active_count,
    output logic [pva_pkg::NUM_VOICES-1:0] active_mask,
    output logic [pva_pkg::WAVE_W-1:0]    slot_wave
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [pva_pkg::SLOT_W-1:0] LAST_SLOT =
        pva_pkg::SLOT_W'(pva_pkg::NUM_VOICES - 1);

    // Control state
    logic [1:0]                      state_reg, state_next;
    logic [pva_pkg::SLOT_W-1:0]      idx_reg;
    pva_pkg::cmd_t                   op_reg;
    logic [pva_pkg::NUM_VOICES-1:0]  active_reg, active_next;
    logic [pva_pkg::CNT_W-1:0]       cnt_reg;
    logic                            match_found_reg;
    logic                            free_found_reg;
    logic                            low_found_reg;
    logic                            out_valid_reg;

    // Scan trackers (payload)
    logic [pva_pkg::SLOT_W-1:0]      match_slot_reg;
    logic [pva_pkg::WAVE_W-1:0]      match_wave_reg;
    logic [pva_pkg::SLOT_W-1:0]      free_slot_reg;
    logic [pva_pkg::SLOT_W-1:0]      low_slot_reg;
    logic [pva_pkg::LEVEL_W-1:0]     low_level_reg;

    // Voice storage
    logic [pva_pkg::NOTE_W-1:0]      note_reg     [pva_pkg::NUM_VOICES];
    logic [pva_pkg::CHAN_W-1:0]      chan_reg     [pva_pkg::NUM_VOICES];
    logic [pva_pkg::WAVE_W-1:0]      wave_reg     [pva_pkg::NUM_VOICES];
    logic [pva_pkg::LEVEL_W-1:0]     level_reg    [pva_pkg::NUM_VOICES];
    logic                            released_reg [pva_pkg::NUM_VOICES];

    // Output register
    logic [pva_pkg::SLOT_W-1:0]      out_slot_reg;
    logic [2:0]                      out_outcome_reg;
    logic [pva_pkg::CNT_W-1:0]       out_count_reg;
    logic [pva_pkg::NUM_VOICES-1:0]  out_mask_reg;
    logic [pva_pkg::WAVE_W-1:0]      out_wave_reg;

    // Scan datapath
    logic                            cur_active;
    logic [pva_pkg::LEVEL_W-1:0]     cur_level;
    logic                            cur_match;
    logic [pva_pkg::LEVEL_W:0]       rise_sum;
    logic [pva_pkg::LEVEL_W-1:0]     tick_level;
    logic                            tick_keep;
    logic                            keep_bit;
    logic                            is_tick;
    logic                            out_free;
    logic                            commit;

    // Write controls for voice storage
    logic                            lvl_we;
    logic [pva_pkg::SLOT_W-1:0]      lvl_addr;
    logic [pva_pkg::LEVEL_W-1:0]     lvl_data;
    logic                            rel_we;
    logic                            rel_data;
    logic                            alloc_we;

    // Commit results
    logic [pva_pkg::SLOT_W-1:0]      fin_slot;
    logic [2:0]                      fin_outcome;
    logic [pva_pkg::CNT_W-1:0]       fin_count;
    logic [pva_pkg::WAVE_W-1:0]      fin_wave;

    assign is_tick    = (op_reg.act == pva_pkg::ACT_TICK);
    assign cur_active = active_reg[idx_reg];
    assign cur_level  = level_reg[idx_reg];
    assign cur_match  = cur_active && (chan_reg[idx_reg] == op_reg.channel)
                        && (note_reg[idx_reg] == op_reg.note);
    assign out_free   = !out_valid_reg || !out_stall;
    assign commit     = (state_reg == ST_FIN) && out_free;
    assign cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;

    // Advance one voice envelope by a tick
    always_comb
    begin
        rise_sum   = {1'b0, cur_level} + {1'b0, cfg.attack_step};
        tick_level = cur_level;
        tick_keep  = cur_active;
        if (cur_active)
        begin
            if (released_reg[idx_reg])
            begin
                if (cur_level <= cfg.release_step)
                begin
                    tick_keep = 1'b0;
                end
                else
                begin
                    tick_level = cur_level - cfg.release_step;
                end
            end
            else if (rise_sum > {1'b0, pva_pkg::LEVEL_ONE})
            begin
                tick_level = pva_pkg::LEVEL_ONE;
            end
            else
            begin
                tick_level = rise_sum[pva_pkg::LEVEL_W-1:0];
            end
        end
        keep_bit = is_tick ? tick_keep : cur_active;
    end

    // Decide the result of the finished command
    always_comb
    begin
        fin_slot    = '0;
        fin_outcome = pva_pkg::OUT_NONE;
        fin_count   = cnt_reg;
        fin_wave    = '0;
        alloc_we    = 1'b0;
        unique case (op_reg.act)
            pva_pkg::ACT_NOTE_ON:
            begin
                if (match_found_reg)
                begin
                    fin_slot    = match_slot_reg;
                    fin_outcome = pva_pkg::OUT_RETRIG;
                    fin_wave    = match_wave_reg;
                end
                else if (cnt_reg >= cfg.limit)
                begin
                    fin_slot    = low_slot_reg;
                    fin_outcome = pva_pkg::OUT_STOLEN;
                    fin_wave    = cfg.wave;
                    alloc_we    = 1'b1;
                end
                else
                begin
                    fin_slot    = free_slot_reg;
                    fin_outcome = pva_pkg::OUT_NEW;
                    fin_wave    = cfg.wave;
                    fin_count   = cnt_reg + 1'b1;
                    alloc_we    = 1'b1;
                end
            end
            pva_pkg::ACT_NOTE_OFF:
            begin
                if (match_found_reg)
                begin
                    fin_slot    = match_slot_reg;
                    fin_outcome = pva_pkg::OUT_RELEASED;
                    fin_wave    = match_wave_reg;
                end
                else
                begin
                    fin_outcome = pva_pkg::OUT_NOT_FOUND;
                end
            end
            pva_pkg::ACT_ALL_OFF:
            begin
                fin_count = '0;
            end
            default:
            begin
                fin_count = cnt_reg;
            end
        endcase
    end

    // Steer writes into voice storage and the active vector
    always_comb
    begin
        active_next = active_reg;
        lvl_we      = 1'b0;
        lvl_addr    = idx_reg;
        lvl_data    = tick_level;
        rel_we      = 1'b0;
        rel_data    = 1'b0;
        if (state_reg == ST_SCAN && is_tick)
        begin
            lvl_we               = cur_active;
            active_next[idx_reg] = tick_keep;
        end
        else if (commit)
        begin
            lvl_addr = fin_slot;
            lvl_data = '0;
            if (op_reg.act == pva_pkg::ACT_ALL_OFF)
            begin
                active_next = '0;
            end
            else if (op_reg.act == pva_pkg::ACT_NOTE_ON)
            begin
                lvl_we                = 1'b1;
                rel_we                = 1'b1;
                active_next[fin_slot] = 1'b1;
            end
            else if (op_reg.act == pva_pkg::ACT_NOTE_OFF && match_found_reg)
            begin
                rel_we   = 1'b1;
                rel_data = 1'b1;
            end
        end
    end

    // Sequence the command
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = cmd.needs_scan ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            op_reg          <= '0;
            active_reg      <= '0;
            cnt_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            low_found_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            if (cmd_pop)
            begin
                op_reg          <= cmd;
                idx_reg         <= '0;
                cnt_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                low_found_reg   <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + 1'b1;
                cnt_reg <= cnt_reg + pva_pkg::CNT_W'(keep_bit);
                if (cur_match)
                begin
                    match_found_reg <= 1'b1;
                end
                if (!cur_active)
                begin
                    free_found_reg <= 1'b1;
                end
                if (cur_active)
                begin
                    low_found_reg <= 1'b1;
                end
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Track first match, first free slot and lowest level
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            if (cur_match && !match_found_reg)
            begin
                match_slot_reg <= idx_reg;
                match_wave_reg <= wave_reg[idx_reg];
            end
            if (!cur_active && !free_found_reg)
            begin
                free_slot_reg <= idx_reg;
            end
            if (cur_active && (!low_found_reg || cur_level < low_level_reg))
            begin
                low_slot_reg  <= idx_reg;
                low_level_reg <= cur_level;
            end
        end
    end

    // Write voice storage
    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            level_reg[lvl_addr] <= lvl_data;
        end
        if (rel_we)
        begin
            released_reg[lvl_addr] <= rel_data;
        end
        if (commit && alloc_we)
        begin
            note_reg[fin_slot] <= op_reg.note;
            chan_reg[fin_slot] <= op_reg.channel;
            wave_reg[fin_slot] <= cfg.wave;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_slot_reg    <= fin_slot;
            out_outcome_reg <= fin_outcome;
            out_count_reg   <= fin_count;
            out_mask_reg    <= active_next;
            out_wave_reg    <= fin_wave;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot         = out_slot_reg;
    assign outcome      = out_outcome_reg;
    assign active_count = out_count_reg;
    assign active_mask  = out_mask_reg;
    assign slot_wave    = out_wave_reg;

    // Reported count always agrees with the reported mask
    `PVA_ASSERT(a_count_mask, !out_valid_reg || ($countones(out_mask_reg) == int'(out_count_reg)))
    // A fresh allocation never pushes the count past the limit
    `PVA_ASSERT(a_new_limit, !(out_valid_reg && out_outcome_reg == pva_pkg::OUT_NEW) || (out_count_reg <= cfg.limit))
    // The slot named by a hit is sounding
    `PVA_ASSERT(a_slot_live, !(out_valid_reg && (out_outcome_reg == pva_pkg::OUT_NEW || out_outcome_reg == pva_pkg::OUT_RETRIG || out_outcome_reg == pva_pkg::OUT_STOLEN || out_outcome_reg == pva_pkg::OUT_RELEASED)) || out_mask_reg[out_slot_reg])
    // Finishing a command presents a result next cycle
    `PVA_ASSERT_NEXT(a_fin_out, commit, out_valid_reg)
    // The scan only starts from a popped command
    `PVA_ASSERT_NEXT(a_scan_entry, state_reg == ST_IDLE && !cmd_valid, state_reg == ST_IDLE)

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the polyphonic voice allocator. A directed table exercises
// empty-pool events, allocation, retrigger, release, freeing on tick,
// stealing and all-off. Random phases then run under many register settings,
// including out-of-range limits, waves and steps. Every result is checked
// field by field against the typed table row or an in-bench voice allocator;
// both handshakes see random idle bursts only in random phases but the last.
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEMS_PER_PHASE = 195;
    localparam int POOL_SIZE       = 10;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic [pva_pkg::SLOT_W-1:0]     slot;
        logic [2:0]                     outcome;
        logic [pva_pkg::CNT_W-1:0]      count;
        logic [pva_pkg::NUM_VOICES-1:0] mask;
        logic [pva_pkg::WAVE_W-1:0]     wave;
    } voice_result_t;

    typedef struct packed {
        logic [1:0]                 act;
        logic [pva_pkg::CHAN_W-1:0] chan;
        logic [pva_pkg::NOTE_W-1:0] note;
        logic                       typed;
        voice_result_t              want;
    } stim_row_t;

    // DUT connections
    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [1:0]                     cfg_index;
    logic [15:0]                    cfg_wdata;
    logic                           in_valid;
    logic                           in_stall;
    logic [1:0]                     action;
    logic [pva_pkg::CHAN_W-1:0]     midi_channel;
    logic [pva_pkg::NOTE_W-1:0]     note_number;
    logic                           out_valid;
    logic                           out_stall;
    logic [pva_pkg::SLOT_W-1:0]     slot;
    logic [2:0]                     outcome;
    logic [pva_pkg::CNT_W-1:0]      active_count;
    logic [pva_pkg::NUM_VOICES-1:0] active_mask;
    logic [pva_pkg::WAVE_W-1:0]     slot_wave;

    // Voice pool as the bench sees it
    bit                             voice_on   [pva_pkg::NUM_VOICES];
    logic [pva_pkg::NOTE_W-1:0]     voice_key  [pva_pkg::NUM_VOICES];
    logic [pva_pkg::CHAN_W-1:0]     voice_chan [pva_pkg::NUM_VOICES];
    logic [pva_pkg::WAVE_W-1:0]     voice_wave [pva_pkg::NUM_VOICES];
    int                             voice_lvl  [pva_pkg::NUM_VOICES];
    bit                             voice_rel  [pva_pkg::NUM_VOICES];

    // Register copies, as written
    logic [3:0]            limit_reg;
    logic [6:0]            wave_reg;
    logic [15:0]           attack_reg;
    logic [15:0]           release_reg;

    voice_result_t                  pending_results[$];
    stim_row_t                      directed_rows[$];
    logic [pva_pkg::CHAN_W-1:0]     pool_chan [POOL_SIZE];
    logic [pva_pkg::NOTE_W-1:0]     pool_note [POOL_SIZE];

    int  cycles;
    int  mismatches;
    int  transfers;
    int  results_checked;
    int  settings_run;
    int  outcome_hits [8];
    int  stall_left;
    bit  send_gaps;
    bit  recv_gaps;
    voice_result_t got;
    voice_result_t exp_res;

    poly_voice_allocator_envelope u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .midi_channel (midi_channel),
        .note_number  (note_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot         (slot),
        .outcome      (outcome),
        .active_count (active_count),
        .active_mask  (active_mask),
        .slot_wave    (slot_wave)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output stall in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (recv_gaps && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 15);
        out_stall <= (stall_left > 0);
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{slot, outcome, active_count, active_mask, slot_wave};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result at cycle %0d: %p", cycles, got);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (got.slot !== exp_res.slot || got.outcome !== exp_res.outcome ||
                    got.count !== exp_res.count || got.mask !== exp_res.mask ||
                    got.wave !== exp_res.wave)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at cycle %0d: expected %p, got %p",
                                 cycles, exp_res, got);
                end
            end
        end
    end

    function automatic int find_voice(input logic [pva_pkg::CHAN_W-1:0] ch,
                                      input logic [pva_pkg::NOTE_W-1:0] nt);
        int hit;
        hit = -1;
        for (int v = pva_pkg::NUM_VOICES - 1; v >= 0; v--)
            if (voice_on[v] && voice_chan[v] == ch && voice_key[v] == nt)
                hit = v;
        return hit;
    endfunction

    function automatic int voices_sounding();
        int n;
        n = 0;
        for (int v = 0; v < pva_pkg::NUM_VOICES; v++)
            if (voice_on[v])
                n++;
        return n;
    endfunction

    function automatic void free_voice(input int v);
        voice_on[v]   = 1'b0;
        voice_key[v]  = '0;
        voice_chan[v] = '0;
        voice_wave[v] = '0;
        voice_lvl[v]  = 0;
        voice_rel[v]  = 1'b0;
    endfunction

    // Apply one event to the voice pool and return the result it gives
    function automatic voice_result_t next_voice_result(
        input logic [1:0]                 act,
        input logic [pva_pkg::CHAN_W-1:0] ch,
        input logic [pva_pkg::NOTE_W-1:0] nt);
        voice_result_t r;
        int s;
        int lim;
        int up;
        int dn;
        logic [pva_pkg::WAVE_W-1:0] w;
        r = '0;
        case (act)
            pva_pkg::ACT_NOTE_ON:
            begin
                s = find_voice(ch, nt);
                if (s >= 0)
                begin
                    voice_lvl[s] = 0;
                    voice_rel[s] = 1'b0;
                    r.outcome = pva_pkg::OUT_RETRIG;
                end
                else
                begin
                    lim = (limit_reg < 1) ? 1 :
                          (limit_reg > pva_pkg::NUM_VOICES) ? pva_pkg::NUM_VOICES
                                                            : limit_reg;
                    w = (wave_reg > pva_pkg::WAVE_MAX) ? pva_pkg::WAVE_MAX : wave_reg;
                    if (voices_sounding() >= lim)
                    begin
                        // Steal the quietest voice, lowest slot on ties
                        for (int v = 0; v < pva_pkg::NUM_VOICES; v++)
                            if (voice_on[v] && (s < 0 || voice_lvl[v] < voice_lvl[s]))
                                s = v;
                        r.outcome = pva_pkg::OUT_STOLEN;
                    end
                    else
                    begin
                        for (int v = 0; v < pva_pkg::NUM_VOICES; v++)
                            if (s < 0 && !voice_on[v])
                                s = v;
                        r.outcome = pva_pkg::OUT_NEW;
                    end
                    voice_on[s]   = 1'b1;
                    voice_key[s]  = nt;
                    voice_chan[s] = ch;
                    voice_wave[s] = w;
                    voice_lvl[s]  = 0;
                    voice_rel[s]  = 1'b0;
                end
                r.slot = pva_pkg::SLOT_W'(s);
                r.wave = voice_wave[s];
            end
            pva_pkg::ACT_NOTE_OFF:
            begin
                s = find_voice(ch, nt);
                if (s >= 0)
                begin
                    voice_rel[s] = 1'b1;
                    r.slot = pva_pkg::SLOT_W'(s);
                    r.wave = voice_wave[s];
                    r.outcome = pva_pkg::OUT_RELEASED;
                end
                else
                    r.outcome = pva_pkg::OUT_NOT_FOUND;
            end
            pva_pkg::ACT_ALL_OFF:
            begin
                for (int v = 0; v < pva_pkg::NUM_VOICES; v++)
                    free_voice(v);
            end
            default:
            begin
                up = (attack_reg == 0) ? 1 :
                     (attack_reg > pva_pkg::LEVEL_ONE) ? pva_pkg::LEVEL_ONE : attack_reg;
                dn = (release_reg == 0) ? 1 :
                     (release_reg > pva_pkg::LEVEL_ONE) ? pva_pkg::LEVEL_ONE : release_reg;
                for (int v = 0; v < pva_pkg::NUM_VOICES; v++)
                begin
                    if (voice_on[v])
                    begin
                        if (voice_rel[v])
                        begin
                            if (voice_lvl[v] <= dn)
                                free_voice(v);
                            else
                                voice_lvl[v] -= dn;
                        end
                        else
                        begin
                            voice_lvl[v] += up;
                            if (voice_lvl[v] > pva_pkg::LEVEL_ONE)
                                voice_lvl[v] = pva_pkg::LEVEL_ONE;
                        end
                    end
                end
            end
        endcase
        for (int v = 0; v < pva_pkg::NUM_VOICES; v++)
            r.mask[v] = voice_on[v];
        r.count = pva_pkg::CNT_W'(voices_sounding());
        return r;
    endfunction

    // Send one event; predict its result at the transfer edge
    task automatic send_event(input logic [1:0] act,
                              input logic [pva_pkg::CHAN_W-1:0] ch,
                              input logic [pva_pkg::NOTE_W-1:0] nt, input bit typed,
                              input voice_result_t want);
        voice_result_t r;
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        midi_channel <= ch;
        note_number  <= nt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = next_voice_result(act, ch, nt);
        if (typed)
            r = want;
        pending_results.push_back(r);
        outcome_hits[r.outcome]++;
        transfers++;
    endtask

    // Hold input and wait until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Write all four registers while the block is idle
    task automatic write_regs(input logic [15:0] lim, input logic [15:0] wav,
                              input logic [15:0] att, input logic [15:0] rel);
        cfg_we    <= 1'b1;
        cfg_index <= pva_pkg::REG_LIMIT;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_index <= pva_pkg::REG_WAVE;
        cfg_wdata <= wav;
        @(posedge clk);
        cfg_index <= pva_pkg::REG_ATTACK;
        cfg_wdata <= att;
        @(posedge clk);
        cfg_index <= pva_pkg::REG_RELEASE;
        cfg_wdata <= rel;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg   = lim[3:0];
        wave_reg    = wav[6:0];
        attack_reg  = att;
        release_reg = rel;
    endtask

    task automatic add_row(input logic [1:0] act, input logic [pva_pkg::CHAN_W-1:0] ch,
                           input logic [pva_pkg::NOTE_W-1:0] nt, input bit typed,
                           input voice_result_t want);
        directed_rows.push_back('{act, ch, nt, typed, want});
    endtask

    // One random event: ticks, pool notes so voices collide, some noise
    task automatic random_event();
        int pick;
        int k;
        int live[$];
        logic [1:0] act;
        logic [pva_pkg::CHAN_W-1:0] ch;
        logic [pva_pkg::NOTE_W-1:0] nt;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, POOL_SIZE - 1);
        ch = pool_chan[k];
        nt = pool_note[k];
        if (pick < 45)
        begin
            act = pva_pkg::ACT_TICK;
            ch = pva_pkg::CHAN_W'($urandom);
            nt = pva_pkg::NOTE_W'($urandom);
        end
        else if (pick < 75)
            act = pva_pkg::ACT_NOTE_ON;
        else if (pick < 93)
        begin
            act = pva_pkg::ACT_NOTE_OFF;
            for (int v = 0; v < pva_pkg::NUM_VOICES; v++)
                if (voice_on[v])
                    live.push_back(v);
            if (live.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                k = live[$urandom_range(0, live.size() - 1)];
                ch = voice_chan[k];
                nt = voice_key[k];
            end
        end
        else if (pick < 95)
        begin
            act = pva_pkg::ACT_ALL_OFF;
            ch = pva_pkg::CHAN_W'($urandom);
            nt = pva_pkg::NOTE_W'($urandom);
        end
        else
        begin
            act = 2'($urandom_range(0, 3));
            ch = pva_pkg::CHAN_W'($urandom);
            nt = pva_pkg::NOTE_W'($urandom);
        end
        send_event(act, ch, nt, 1'b0, '0);
    endtask

    // One register setting followed by a block of random events
    task automatic run_phase(input logic [15:0] lim, input logic [15:0] wav,
                             input logic [15:0] att, input logic [15:0] rel,
                             input bit quiet);
        if (quiet)
        begin
            send_gaps = 1'b0;
            recv_gaps = 1'b0;
        end
        write_regs(lim, wav, att, rel);
        settings_run++;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            pool_chan[k] = pva_pkg::CHAN_W'($urandom);
            pool_note[k] = pva_pkg::NOTE_W'($urandom);
        end
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
        begin
            if (i % 50 == 0)
            begin
                send_gaps = !quiet && $urandom_range(0, 2) != 0;
                recv_gaps = !quiet && $urandom_range(0, 2) != 0;
            end
            if (i == ITEMS_PER_PHASE / 2)
                wait_drained();
            random_event();
        end
        wait_drained();
    endtask

    initial
    begin
        in_valid     <= 1'b0;
        action       <= pva_pkg::ACT_NOTE_ON;
        midi_channel <= '0;
        note_number  <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= pva_pkg::REG_LIMIT;
        cfg_wdata    <= '0;
        rst_n        <= 1'b0;
        send_gaps   = 1'b0;
        recv_gaps   = 1'b0;
        limit_reg   = 4'd8;
        wave_reg    = 7'd0;
        attack_reg  = 16'd171;
        release_reg = 16'd6;
        for (int v = 0; v < pva_pkg::NUM_VOICES; v++)
            free_voice(v);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pool, fill, match, release, free on tick, steal
        add_row(pva_pkg::ACT_TICK,     5'd0,  7'd0,   1'b1,
                '{3'd0, pva_pkg::OUT_NONE,      4'd0, 8'h00, 7'd0});
        add_row(pva_pkg::ACT_NOTE_OFF, 5'd31, 7'd127, 1'b1,
                '{3'd0, pva_pkg::OUT_NOT_FOUND, 4'd0, 8'h00, 7'd0});
        add_row(pva_pkg::ACT_ALL_OFF,  5'd31, 7'd127, 1'b1,
                '{3'd0, pva_pkg::OUT_NONE,      4'd0, 8'h00, 7'd0});
        add_row(pva_pkg::ACT_NOTE_ON,  5'd0,  7'd0,   1'b1,
                '{3'd0, pva_pkg::OUT_NEW,       4'd1, 8'h01, 7'd0});
        add_row(pva_pkg::ACT_NOTE_ON,  5'd31, 7'd127, 1'b1,
                '{3'd1, pva_pkg::OUT_NEW,       4'd2, 8'h03, 7'd0});
        add_row(pva_pkg::ACT_NOTE_ON,  5'd16, 7'd0,   1'b1,
                '{3'd2, pva_pkg::OUT_NEW,       4'd3, 8'h07, 7'd0});
        add_row(pva_pkg::ACT_NOTE_ON,  5'd0,  7'd64,  1'b1,
                '{3'd3, pva_pkg::OUT_NEW,       4'd4, 8'h0F, 7'd0});
        add_row(pva_pkg::ACT_NOTE_ON,  5'd0,  7'd0,   1'b1,
                '{3'd0, pva_pkg::OUT_RETRIG,    4'd4, 8'h0F, 7'd0});
        add_row(pva_pkg::ACT_NOTE_OFF, 5'd31, 7'd127, 1'b1,
                '{3'd1, pva_pkg::OUT_RELEASED,  4'd4, 8'h0F, 7'd0});
        add_row(pva_pkg::ACT_NOTE_OFF, 5'd15, 7'd127, 1'b1,
                '{3'd0, pva_pkg::OUT_NOT_FOUND, 4'd4, 8'h0F, 7'd0});
        add_row(pva_pkg::ACT_TICK,     5'd0,  7'd0,   1'b1,
                '{3'd0, pva_pkg::OUT_NONE,      4'd3, 8'h0D, 7'd0});
        add_row(pva_pkg::ACT_NOTE_ON,  5'd1,  7'd1,   1'b0, '0);
        add_row(pva_pkg::ACT_NOTE_ON,  5'd2,  7'd2,   1'b0, '0);
        add_row(pva_pkg::ACT_NOTE_ON,  5'd3,  7'd3,   1'b0, '0);
        add_row(pva_pkg::ACT_NOTE_ON,  5'd4,  7'd4,   1'b0, '0);
        add_row(pva_pkg::ACT_NOTE_ON,  5'd5,  7'd5,   1'b0, '0);
        add_row(pva_pkg::ACT_TICK,     5'd7,  7'd99,  1'b0, '0);
        add_row(pva_pkg::ACT_NOTE_ON,  5'd9,  7'd9,   1'b0, '0);
        add_row(pva_pkg::ACT_NOTE_OFF, 5'd9,  7'd9,   1'b0, '0);
        add_row(pva_pkg::ACT_NOTE_OFF, 5'd16, 7'd0,   1'b0, '0);
        add_row(pva_pkg::ACT_TICK,     5'd0,  7'd0,   1'b0, '0);
        add_row(pva_pkg::ACT_ALL_OFF,  5'd0,  7'd0,   1'b1,
                '{3'd0, pva_pkg::OUT_NONE,      4'd0, 8'h00, 7'd0});
        add_row(pva_pkg::ACT_TICK,     5'd0,  7'd0,   1'b1,
                '{3'd0, pva_pkg::OUT_NONE,      4'd0, 8'h00, 7'd0});
        foreach (directed_rows[i])
            send_event(directed_rows[i].act, directed_rows[i].chan, directed_rows[i].note,
                       directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // Random phases across register settings, extremes included
        run_phase(16'd8,  16'd0,   16'd171,   16'd6,     1'b0);
        run_phase(16'd1,  16'd99,  16'd32768, 16'd32768, 1'b0);
        run_phase(16'd0,  16'd127, 16'd0,     16'd0,     1'b0);
        run_phase(16'd15, 16'd100, 16'hFFFF,  16'hFFFF,  1'b0);
        run_phase(16'd4,  16'd37,  16'd2000,  16'd3000,  1'b0);
        run_phase(16'd3,  16'($urandom_range(0, 127)), 16'($urandom_range(1, 8000)),
                  16'($urandom_range(1, 8000)), 1'b0);
        run_phase(16'hFFF6, 16'hFF80, 16'd32767, 16'd1, 1'b0);
        run_phase(16'd2,  16'($urandom_range(0, 127)), 16'($urandom), 16'($urandom), 1'b0);
        run_phase(16'd8,  16'd50,  16'd5000,  16'd4096,  1'b0);
        run_phase(16'($urandom_range(0, 15)), 16'($urandom_range(0, 127)),
                  16'($urandom_range(1, 12000)), 16'($urandom_range(1, 12000)), 1'b1);

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            mismatches += pending_results.size();

        $display("Sent %0d events over %0d register settings; checked %0d results",
                 transfers, settings_run, results_checked);
        $display("Outcomes: new %0d, retrigger %0d, stolen %0d, released %0d, not found %0d",
                 outcome_hits[pva_pkg::OUT_NEW], outcome_hits[pva_pkg::OUT_RETRIG],
                 outcome_hits[pva_pkg::OUT_STOLEN], outcome_hits[pva_pkg::OUT_RELEASED],
                 outcome_hits[pva_pkg::OUT_NOT_FOUND]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
